@@ rtl/sfc_pkg.sv @@
package sfc_pkg;

  localparam int FRAME_BUF   = 20;
  localparam int FRAME_LEN_W = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Command kinds
  localparam logic [3:0] OP_ENABLE      = 4'd0;
  localparam logic [3:0] OP_STOP        = 4'd1;
  localparam logic [3:0] OP_CTRL_MODE   = 4'd2;
  localparam logic [3:0] OP_CLR_STALL   = 4'd3;
  localparam logic [3:0] OP_SYNC        = 4'd4;
  localparam logic [3:0] OP_VELOCITY    = 4'd5;
  localparam logic [3:0] OP_POSITION    = 4'd6;
  localparam logic [3:0] OP_READ_PARAM  = 4'd7;
  localparam logic [3:0] OP_SET_ZERO    = 4'd8;
  localparam logic [3:0] OP_HOME_TRIG   = 4'd9;
  localparam logic [3:0] OP_HOME_RDPAR  = 4'd10;
  localparam logic [3:0] OP_HOME_WRPAR  = 4'd11;
  localparam logic [3:0] OP_HOME_STATUS = 4'd12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOME_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_CURRENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_TIME    = 3'd3;

  localparam logic [7:0] TAIL_BYTE     = 8'h6B;
  localparam logic [7:0] MAX_PARAM_SEL = 8'd13;
  localparam logic [7:0] PARAM_SEL_A   = 8'd12;
  localparam logic [7:0] PARAM_SEL_B   = 8'd13;
  localparam logic [7:0] PARAM_EXT_A   = 8'h6C;
  localparam logic [7:0] PARAM_EXT_B   = 8'h7A;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  addr;
    logic [7:0]  dir;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [31:0] pulse_count;
    logic        flag_a;
    logic        flag_b;
    logic [7:0]  sub_code;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [31:0] homing_timeout_ms;
    logic [15:0] collision_speed;
    logic [15:0] collision_current;
    logic [15:0] collision_time;
  } home_cfg_t;

  // One slot of the byte chain
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } slot_t;

  function automatic logic [7:0] param_code(input logic [3:0] sel);
    logic [7:0] code;
    case (sel)
      4'd0:    code = 8'h1F;
      4'd1:    code = 8'h20;
      4'd2:    code = 8'h21;
      4'd3:    code = 8'h24;
      4'd4:    code = 8'h27;
      4'd5:    code = 8'h31;
      4'd6:    code = 8'h33;
      4'd7:    code = 8'h35;
      4'd8:    code = 8'h36;
      4'd9:    code = 8'h37;
      4'd10:   code = 8'h3A;
      4'd11:   code = 8'h3B;
      4'd12:   code = 8'h42;
      4'd13:   code = 8'h43;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/sfc_frame.sv @@
module sfc_frame (
  input  sfc_pkg::in_t                                 cmd,
  input  sfc_pkg::home_cfg_t                           hcfg,
  output logic [sfc_pkg::FRAME_BUF-1:0][7:0]           bytes,
  output logic [sfc_pkg::FRAME_LEN_W-1:0]              len
);

  logic [7:0] fa;
  logic [7:0] fb;

  assign fa = {7'd0, cmd.flag_a};
  assign fb = {7'd0, cmd.flag_b};

  always_comb begin
    bytes    = '0;
    len      = '0;
    bytes[0] = cmd.addr;
    case (cmd.op)
      sfc_pkg::OP_ENABLE: begin
        bytes[1] = 8'hF3; bytes[2] = 8'hAB; bytes[3] = fa; bytes[4] = fb;
        bytes[5] = sfc_pkg::TAIL_BYTE;
        len = 5'd6;
      end
      sfc_pkg::OP_STOP: begin
        bytes[1] = 8'hFE; bytes[2] = 8'h98; bytes[3] = fb;
        bytes[4] = sfc_pkg::TAIL_BYTE;
        len = 5'd5;
      end
      sfc_pkg::OP_CTRL_MODE: begin
        bytes[1] = 8'h46; bytes[2] = 8'h69; bytes[3] = fa; bytes[4] = cmd.sub_code;
        bytes[5] = sfc_pkg::TAIL_BYTE;
        len = 5'd6;
      end
      sfc_pkg::OP_CLR_STALL: begin
        bytes[1] = 8'h0E; bytes[2] = 8'h52; bytes[3] = sfc_pkg::TAIL_BYTE;
        len = 5'd4;
      end
      sfc_pkg::OP_SYNC: begin
        bytes[1] = 8'hFF; bytes[2] = 8'h66; bytes[3] = sfc_pkg::TAIL_BYTE;
        len = 5'd4;
      end
      sfc_pkg::OP_VELOCITY: begin
        bytes[1] = 8'hF6; bytes[2] = cmd.dir;
        bytes[3] = cmd.speed[15:8]; bytes[4] = cmd.speed[7:0];
        bytes[5] = cmd.accel; bytes[6] = fb;
        bytes[7] = sfc_pkg::TAIL_BYTE;
        len = 5'd8;
      end
      sfc_pkg::OP_POSITION: begin
        bytes[1]  = 8'hFD; bytes[2] = cmd.dir;
        bytes[3]  = cmd.speed[15:8]; bytes[4] = cmd.speed[7:0];
        bytes[5]  = cmd.accel;
        bytes[6]  = cmd.pulse_count[31:24]; bytes[7] = cmd.pulse_count[23:16];
        bytes[8]  = cmd.pulse_count[15:8];  bytes[9] = cmd.pulse_count[7:0];
        bytes[10] = fa; bytes[11] = fb;
        bytes[12] = sfc_pkg::TAIL_BYTE;
        len = 5'd13;
      end
      sfc_pkg::OP_READ_PARAM: begin
        if (cmd.sub_code <= sfc_pkg::MAX_PARAM_SEL) begin
          bytes[1] = sfc_pkg::param_code(cmd.sub_code[3:0]);
          if (cmd.sub_code == sfc_pkg::PARAM_SEL_A) begin
            bytes[2] = sfc_pkg::PARAM_EXT_A; bytes[3] = sfc_pkg::TAIL_BYTE;
            len = 5'd4;
          end else if (cmd.sub_code == sfc_pkg::PARAM_SEL_B) begin
            bytes[2] = sfc_pkg::PARAM_EXT_B; bytes[3] = sfc_pkg::TAIL_BYTE;
            len = 5'd4;
          end else begin
            bytes[2] = sfc_pkg::TAIL_BYTE;
            len = 5'd3;
          end
        end
      end
      sfc_pkg::OP_SET_ZERO: begin
        bytes[1] = 8'h93; bytes[2] = 8'h88; bytes[3] = fa;
        bytes[4] = sfc_pkg::TAIL_BYTE;
        len = 5'd5;
      end
      sfc_pkg::OP_HOME_TRIG: begin
        bytes[1] = 8'h9A; bytes[2] = cmd.sub_code; bytes[3] = fb;
        bytes[4] = sfc_pkg::TAIL_BYTE;
        len = 5'd5;
      end
      sfc_pkg::OP_HOME_RDPAR: begin
        bytes[1] = 8'h22; bytes[2] = sfc_pkg::TAIL_BYTE;
        len = 5'd3;
      end
      sfc_pkg::OP_HOME_WRPAR: begin
        bytes[1]  = 8'h4C; bytes[2] = 8'hAE; bytes[3] = fa; bytes[4] = cmd.sub_code;
        bytes[5]  = cmd.dir;
        bytes[6]  = cmd.speed[15:8]; bytes[7] = cmd.speed[7:0];
        bytes[8]  = hcfg.homing_timeout_ms[31:24];
        bytes[9]  = hcfg.homing_timeout_ms[23:16];
        bytes[10] = hcfg.homing_timeout_ms[15:8];
        bytes[11] = hcfg.homing_timeout_ms[7:0];
        bytes[12] = hcfg.collision_speed[15:8];
        bytes[13] = hcfg.collision_speed[7:0];
        bytes[14] = hcfg.collision_current[15:8];
        bytes[15] = hcfg.collision_current[7:0];
        bytes[16] = hcfg.collision_time[15:8];
        bytes[17] = hcfg.collision_time[7:0];
        bytes[18] = fb;
        bytes[19] = sfc_pkg::TAIL_BYTE;
        len = 5'd20;
      end
      sfc_pkg::OP_HOME_STATUS: begin
        bytes[1] = 8'h3B; bytes[2] = sfc_pkg::TAIL_BYTE;
        len = 5'd3;
      end
      default: len = '0;
    endcase
  end

endmodule

@@ rtl/sfc_cell.sv @@
module sfc_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  sfc_pkg::slot_t load_slot,
  input  sfc_pkg::slot_t next_slot,
  output sfc_pkg::slot_t slot
);

  sfc_pkg::slot_t slot_r;
  sfc_pkg::slot_t slot_nxt;

  // Take a fresh byte on load, otherwise advance from the neighbor
  assign slot_nxt = load ? load_slot : next_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.last <= slot_nxt.last;
    slot_r.data <= slot_nxt.data;
  end

  assign slot = slot_r;

endmodule

@@ rtl/stepper_command_framer.sv @@
// Channel   Ports                               Direction  Handshake
// command   start, busy, in_cmd                 in         start & !busy
// frame     out_valid, out_data                 out        strobe, one cycle
// config    cfg_we, cfg_index, cfg_data         in         write on cfg_we
//
// A frame of L bytes (3 to 20) leaves one byte per cycle; a new command is
// taken in the cycle its predecessor's last byte moves to the output
// register, as the shift chain drains one cell per clock. A command that
// emits nothing leaves the chain free for the next command.
// The first byte of a frame is loaded into head cell 0 on the accepting edge,
// then registered onto out_data by the output register.
// Reset (synchronous, rst_n low) empties the chain and restores the homing
// registers. The receiver cannot stall; every strobe is a delivered byte.
module stepper_command_framer #(
  parameter int MAX_FRAME_BYTES = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  sfc_pkg::in_t                         in_cmd,
  output logic                                 out_valid,
  output sfc_pkg::out_t                        out_data,
  input  logic                                 cfg_we,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int N     = MAX_FRAME_BYTES;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = (CNT_W > sfc_pkg::FRAME_LEN_W) ? CNT_W : sfc_pkg::FRAME_LEN_W;

  // Homing configuration
  sfc_pkg::home_cfg_t hcfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcfg_r.homing_timeout_ms <= 32'd10000;
      hcfg_r.collision_speed   <= 16'd300;
      hcfg_r.collision_current <= 16'd800;
      hcfg_r.collision_time    <= 16'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        sfc_pkg::REG_HOME_TIMEOUT: hcfg_r.homing_timeout_ms <= cfg_data;
        sfc_pkg::REG_COLL_SPEED:   hcfg_r.collision_speed   <= cfg_data[15:0];
        sfc_pkg::REG_COLL_CURRENT: hcfg_r.collision_current <= cfg_data[15:0];
        sfc_pkg::REG_COLL_TIME:    hcfg_r.collision_time    <= cfg_data[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Build the whole frame for the request in hand
  logic [sfc_pkg::FRAME_BUF-1:0][7:0] frame_bytes;
  logic [sfc_pkg::FRAME_LEN_W-1:0]    frame_len;
  logic [CMP_W-1:0]                   len_ext;
  logic                               keep;
  logic                               load;

  sfc_frame u_frame (
    .cmd   (in_cmd),
    .hcfg  (hcfg_r),
    .bytes (frame_bytes),
    .len   (frame_len)
  );

  assign len_ext = CMP_W'(frame_len);
  // Drop a frame that will not fit the chain
  assign keep    = (frame_len != '0) && (len_ext <= CMP_W'(MAX_FRAME_BYTES));
  assign load    = start && !busy;

  // Chain of byte cells; cell 0 feeds the output register
  sfc_pkg::slot_t [N-1:0] slot;
  sfc_pkg::slot_t [N-1:0] load_slot;
  logic [N-1:0]           valid_vec;
  logic [N-1:0]           last_vec;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      sfc_pkg::slot_t nb;

      if (k < sfc_pkg::FRAME_BUF) begin : g_src
        assign load_slot[k].valid = keep && (CMP_W'(k) < len_ext);
        assign load_slot[k].last  = keep && (CMP_W'(k + 1) == len_ext);
        assign load_slot[k].data  = frame_bytes[k];
      end else begin : g_nosrc
        assign load_slot[k] = '0;
      end

      if (k == N - 1) begin : g_end
        assign nb = '0;
      end else begin : g_mid
        assign nb = slot[k+1];
      end

      sfc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_slot (load_slot[k]),
        .next_slot (nb),
        .slot      (slot[k])
      );

      assign valid_vec[k] = slot[k].valid;
      assign last_vec[k]  = slot[k].last;
    end
  endgenerate

  // Busy while any byte beyond the head cell is still queued; the head byte
  // moves to the output register in the same cycle a new request loads.
  assign busy = |valid_vec[N-1:1];

  // Output register: advance the head cell every cycle
  logic          out_valid_r;
  sfc_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= slot[0].valid;
    end
    out_r.frame_byte <= slot[0].data;
    out_r.last_byte  <= slot[0].last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Queued bytes always sit packed against the head cell
  a_packed_head: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> slot[0].valid)
    else $error("queued bytes not packed against head cell");

  // At most one frame end sits in the chain
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(last_vec & valid_vec) <= 1)
    else $error("more than one frame end in chain");

  // A request of unknown kind leaves the chain free
  a_unknown_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_cmd.op > sfc_pkg::OP_HOME_STATUS) |=> !busy)
    else $error("unknown request occupied the chain");

  // A frame's final byte in the head cell carries the tail code
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (slot[0].valid && slot[0].last) |-> (slot[0].data == sfc_pkg::TAIL_BYTE))
    else $error("frame end without tail byte");

endmodule
